// File: rtl/ptw_pkg.sv
`default_nettype none
package ptw_pkg;

	// fraction bits of every internal value
	localparam int IFB = 24;
	localparam logic [63:0] ONE_Q = 64'd1 << IFB;

	// log2(e) and log2(2*pi), Q.24
	localparam logic [24:0] LOG2E_Q = 25'd24204406;
	localparam logic [25:0] LOG2_2PI_Q = 26'd44484723;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_NORM_C = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLLECTION_FREQ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLLECTION_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TERM_FREQ = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WDF_BOUND = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DOCLEN_MAX = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DOCLEN_MIN = 3'd7;

	// short-cut result of a word: weight forced to zero, invalid flag
	typedef struct packed {
		logic zero;
		logic inv;
	} ptw_flags_t;

endpackage
`default_nettype wire

// File: rtl/ptw_delay.sv
`default_nettype none
module ptw_delay #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	// shift line, advances with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
		end else if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[DEPTH-1];

endmodule
`default_nettype wire

// File: rtl/ptw_div_cell.sv
`default_nettype none
module ptw_div_cell #(
	parameter int DW = 64,
	parameter int QW = 64
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem,
	input  logic [QW-1:0] word,
	input  logic [DW-1:0] den,
	output logic [DW-1:0] rem_q,
	output logic [QW-1:0] word_q,
	output logic [DW-1:0] den_q
);

	logic [DW:0] trial;
	logic        ge;

	// one restoring step: bring in the next dividend bit, try subtract
	assign trial = {rem, word[QW-1]};
	assign ge = trial >= {1'b0, den};

	// word shifts dividend bits out the top and quotient bits in the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
			word_q <= {word[QW-2:0], ge};
			den_q <= den;
		end
	end

endmodule
`default_nettype wire

// File: rtl/ptw_divider.sv
`default_nettype none
module ptw_divider #(
	parameter int DW = 64,
	parameter int QW = 64
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num_hi,
	input  logic [QW-1:0] num_lo,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot
);

	logic [DW-1:0] rem_w [QW+1];
	logic [QW-1:0] word_w [QW+1];
	logic [DW-1:0] den_w [QW];

	assign rem_w[0] = num_hi;
	assign word_w[0] = num_lo;
	assign den_w[0] = den;

	// one quotient bit per cell, QW cells
	for (genvar k = 0; k < QW; k++) begin : g_cell
		if (k < QW - 1) begin : g_mid
			ptw_div_cell #(.DW(DW), .QW(QW)) u_cell (
				.clk(clk), .en(en),
				.rem(rem_w[k]), .word(word_w[k]), .den(den_w[k]),
				.rem_q(rem_w[k+1]), .word_q(word_w[k+1]), .den_q(den_w[k+1])
			);
		end else begin : g_last
			ptw_div_cell #(.DW(DW), .QW(QW)) u_cell (
				.clk(clk), .en(en),
				.rem(rem_w[k]), .word(word_w[k]), .den(den_w[k]),
				.rem_q(rem_w[k+1]), .word_q(word_w[k+1]), .den_q()
			);
		end
	end

	assign quot = word_w[QW];

endmodule
`default_nettype wire

// File: rtl/ptw_log_cell.sv
`default_nettype none
module ptw_log_cell #(
	parameter int WW = 30
) (
	input  logic          clk,
	input  logic          en,
	input  logic [31:0]   m,
	input  logic [WW-1:0] word,
	output logic [31:0]   m_q,
	output logic [WW-1:0] word_q
);

	logic [63:0] sq;
	logic [32:0] mm;
	logic        bit_out;

	// square the Q1.31 mantissa; overflow past 2.0 gives the next bit
	assign sq = m * m;
	assign mm = sq[63:31];
	assign bit_out = mm[32];

	always_ff @(posedge clk) begin
		if (en) begin
			m_q <= bit_out ? mm[32:1] : mm[31:0];
			word_q <= {word[WW-2:0], bit_out};
		end
	end

endmodule
`default_nettype wire

// File: rtl/ptw_log2.sv
`default_nettype none
module ptw_log2 #(
	parameter int XW = 64
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [XW-1:0]                    x,
	output logic [$clog2(XW)+ptw_pkg::IFB-1:0] lg
);

	localparam int NW = $clog2(XW);
	localparam int WW = NW + ptw_pkg::IFB;
	localparam int FB = ptw_pkg::IFB;

	logic [NW-1:0]    msb;
	logic [XW+30:0]   xs;
	logic [31:0]      m_w [FB];
	logic [WW-1:0]    word_w [FB+1];

	// leading one position, then mantissa to Q1.31
	always_comb begin
		msb = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) msb = NW'(i);
		end
	end

	assign xs = {x, 31'b0} >> msb;

	always_ff @(posedge clk) begin
		if (en) begin
			m_w[0] <= xs[31:0];
			word_w[0] <= WW'(msb);
		end
	end

	// one fraction bit per cell; the integer part shifts up to the top
	for (genvar k = 0; k < FB; k++) begin : g_cell
		if (k < FB - 1) begin : g_mid
			ptw_log_cell #(.WW(WW)) u_cell (
				.clk(clk), .en(en),
				.m(m_w[k]), .word(word_w[k]),
				.m_q(m_w[k+1]), .word_q(word_w[k+1])
			);
		end else begin : g_last
			ptw_log_cell #(.WW(WW)) u_cell (
				.clk(clk), .en(en),
				.m(m_w[k]), .word(word_w[k]),
				.m_q(), .word_q(word_w[k+1])
			);
		end
	end

	assign lg = word_w[FB];

endmodule
`default_nettype wire

// File: rtl/pl2_term_weight_unit.sv
`default_nettype none
// PL2 term weight unit. Takes one word per clock (score a posting, or the
// upper bound from the configured bounds) and returns one weight word per
// word, in order; a stalled result holds the whole pipeline, which is
// built mostly from chains of cells: 56-cell dividers for the length
// ratios, 25-stage log2 chains (one squaring per cell), and 64-cell
// dividers for the terms over wdfn+1.
// Weight is signed Q(32-SCORE_FRAC_BITS).SCORE_FRAC_BITS, saturated;
// invalid flags a zero length, zero collection size or zero wdfn.
// The user must write registers only while no word is in flight (not enforced).
module pl2_term_weight_unit #(
	parameter int SCORE_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             action,
	input  logic [31:0]                      term_freq,
	input  logic [31:0]                      doc_length,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic signed [31:0]               weight,
	output logic                             invalid,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ptw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);

	localparam int FB = ptw_pkg::IFB;
	localparam int SH = FB - SCORE_FRAC_BITS;
	localparam int RQW = 56;
	localparam int GQW = 64;
	localparam int LOG_LAT = FB + 1;
	localparam int K_S1 = 1;
	localparam int K_NL = K_S1 + RQW + LOG_LAT;
	localparam int K_S2 = K_NL + 1;
	localparam int K_S3 = K_S2 + LOG_LAT + 1;
	localparam int K_S4 = K_S3 + 1;
	localparam int K_DQ = K_S4 + GQW;
	localparam int K_OUT = K_DQ + 8;
	localparam logic [29:0] NORM_OFS = 30'(FB) << FB;

	logic en;

	// configuration registers
	logic [15:0] length_norm_c_q;
	logic [31:0] average_length_q;
	logic [31:0] collection_freq_q;
	logic [31:0] collection_size_q;
	logic [15:0] query_term_freq_q;
	logic [31:0] wdf_bound_q;
	logic [31:0] doclen_max_q;
	logic [31:0] doclen_min_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_norm_c_q <= 16'd256;
			average_length_q <= 32'd256;
			collection_freq_q <= 32'd0;
			collection_size_q <= 32'd1;
			query_term_freq_q <= 16'd1;
			wdf_bound_q <= 32'd0;
			doclen_max_q <= 32'd1;
			doclen_min_q <= 32'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptw_pkg::CFG_LENGTH_NORM_C: length_norm_c_q <= cfg_data[15:0];
				ptw_pkg::CFG_AVERAGE_LENGTH: average_length_q <= cfg_data;
				ptw_pkg::CFG_COLLECTION_FREQ: collection_freq_q <= cfg_data;
				ptw_pkg::CFG_COLLECTION_SIZE: collection_size_q <= cfg_data;
				ptw_pkg::CFG_QUERY_TERM_FREQ: query_term_freq_q <= cfg_data[15:0];
				ptw_pkg::CFG_WDF_BOUND: wdf_bound_q <= cfg_data;
				ptw_pkg::CFG_DOCLEN_MAX: doclen_max_q <= cfg_data;
				ptw_pkg::CFG_DOCLEN_MIN: doclen_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline moves unless a finished result is stalled
	assign en = !(result_valid && result_stall);
	assign item_stall = !en;

	// short-cut cases of the incoming word
	ptw_pkg::ptw_flags_t flg_in;
	always_comb begin
		flg_in = '{zero: 1'b0, inv: 1'b0};
		if (!action) begin
			if (term_freq == 32'd0) begin
				flg_in.zero = 1'b1;
			end else if (doc_length == 32'd0 || collection_size_q == 32'd0) begin
				flg_in = '{zero: 1'b1, inv: 1'b1};
			end else if (collection_freq_q == 32'd0) begin
				flg_in.zero = 1'b1;
			end
		end else begin
			if (wdf_bound_q == 32'd0) begin
				flg_in.zero = 1'b1;
			end else if (collection_size_q == 32'd0) begin
				flg_in = '{zero: 1'b1, inv: 1'b1};
			end else if (collection_freq_q == 32'd0) begin
				flg_in.zero = 1'b1;
			end else if (doclen_max_q == 32'd0 || doclen_min_q == 32'd0) begin
				flg_in = '{zero: 1'b1, inv: 1'b1};
			end
		end
	end

	// input stage
	logic                action_s1;
	logic [31:0]         wdf_s1;
	logic [31:0]         lena_s1;
	logic [47:0]         cavg_s1;
	ptw_pkg::ptw_flags_t flg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			action_s1 <= action;
			wdf_s1 <= action ? wdf_bound_q : term_freq;
			lena_s1 <= action ? doclen_min_q : doc_length;
			cavg_s1 <= length_norm_c_q * average_length_q;
			flg_s1 <= flg_in;
		end
	end

	// ratio c*avglen/len for the word's length (doclen_min on a bound word) and for the max length bound
	logic [RQW-1:0] ratio_a, ratio_b, mean;

	ptw_divider #(.DW(32), .QW(RQW)) u_div_a (
		.clk(clk), .en(en), .num_hi(32'd0), .num_lo({cavg_s1, 8'b0}),
		.den(lena_s1), .quot(ratio_a)
	);

	ptw_divider #(.DW(32), .QW(RQW)) u_div_b (
		.clk(clk), .en(en), .num_hi(32'd0), .num_lo({cavg_s1, 8'b0}),
		.den(doclen_max_q), .quot(ratio_b)
	);

	// mean = F/N; the user must hold the registers still while a word is in flight
	ptw_divider #(.DW(32), .QW(RQW)) u_div_mean (
		.clk(clk), .en(en), .num_hi(32'd0), .num_lo({collection_freq_q, 24'b0}),
		.den(collection_size_q), .quot(mean)
	);

	logic [29:0] lg_a, lg_b, lg_wu;
	logic [28:0] lg_f, lg_n;

	ptw_log2 #(.XW(64)) u_log_a (
		.clk(clk), .en(en), .x(64'(ratio_a) + ptw_pkg::ONE_Q), .lg(lg_a)
	);

	ptw_log2 #(.XW(64)) u_log_b (
		.clk(clk), .en(en), .x(64'(ratio_b) + ptw_pkg::ONE_Q), .lg(lg_b)
	);

	ptw_log2 #(.XW(32)) u_log_f (
		.clk(clk), .en(en), .x(collection_freq_q), .lg(lg_f)
	);

	ptw_log2 #(.XW(32)) u_log_n (
		.clk(clk), .en(en), .x(collection_size_q), .lg(lg_n)
	);

	// word side fields wait for the normalizing logs
	logic                action_d;
	logic [31:0]         wdf_d;
	ptw_pkg::ptw_flags_t flg_d;

	ptw_delay #(.W(35), .DEPTH(K_NL - K_S1)) u_dly_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({action_s1, wdf_s1, flg_s1}), .q({action_d, wdf_d, flg_d})
	);

	// normalized frequencies
	logic [29:0] nl_a, nl_b;
	logic [61:0] wu_prod;
	logic [63:0] wu_s2, wl_s2;
	ptw_pkg::ptw_flags_t flg_s2;

	assign nl_a = lg_a - NORM_OFS;
	assign nl_b = lg_b - NORM_OFS;
	assign wu_prod = wdf_d * nl_a;

	always_ff @(posedge clk) begin
		if (en) begin
			wu_s2 <= 64'(wu_prod);
			wl_s2 <= action_d ? 64'(nl_b) : 64'(wu_prod);
			flg_s2 <= flg_d;
		end
	end

	// zero wdfn joins the short-cut cases
	ptw_pkg::ptw_flags_t flg_fin, flg_end;
	logic [63:0] g_s2;

	always_comb begin
		flg_fin = flg_s2;
		if (!flg_s2.zero && wu_s2 == 64'd0) flg_fin = '{zero: 1'b1, inv: 1'b1};
	end

	assign g_s2 = wl_s2 + ptw_pkg::ONE_Q;

	ptw_delay #(.W(2), .DEPTH(K_OUT - 1 - K_S2)) u_dly_flg (
		.clk(clk), .arst_n(arst_n), .en(en), .d(flg_fin), .q(flg_end)
	);

	logic [63:0] wu_d, g_d;

	ptw_delay #(.W(128), .DEPTH(K_S4 - K_S2)) u_dly_wug (
		.clk(clk), .arst_n(arst_n), .en(en), .d({wu_s2, g_s2}), .q({wu_d, g_d})
	);

	ptw_log2 #(.XW(64)) u_log_wu (
		.clk(clk), .en(en), .x(wu_s2), .lg(lg_wu)
	);

	// log terms: e = lw - lm - log2e, h = log2(2pi) + lw
	logic signed [33:0] lw, lm, e_v, h_v;
	logic               esg_s3, hsg_s3;
	logic [31:0]        emag_s3, hmag_s3, hmag_s4;
	logic [52:0]        pml_s3, pmh_s3;
	logic [80:0]        num_s4;

	assign lw = $signed({4'b0, lg_wu}) - $signed({4'b0, NORM_OFS});
	assign lm = $signed({5'b0, lg_f}) - $signed({5'b0, lg_n});
	assign e_v = lw - lm - $signed({9'b0, ptw_pkg::LOG2E_Q});
	assign h_v = lw + $signed({8'b0, ptw_pkg::LOG2_2PI_Q});

	always_ff @(posedge clk) begin
		if (en) begin
			esg_s3 <= e_v[33];
			hsg_s3 <= h_v[33];
			emag_s3 <= e_v[33] ? 32'(-e_v) : e_v[31:0];
			hmag_s3 <= h_v[33] ? 32'(-h_v) : h_v[31:0];
			pml_s3 <= mean[27:0] * ptw_pkg::LOG2E_Q;
			pmh_s3 <= mean[55:28] * ptw_pkg::LOG2E_Q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= 81'(pml_s3) + (81'(pmh_s3) << 28);
			hmag_s4 <= hmag_s3;
		end
	end

	// terms over wdfn+1
	logic [63:0] r_q, t2_q, t3_q;

	ptw_divider #(.DW(64), .QW(GQW)) u_div_r (
		.clk(clk), .en(en), .num_hi({40'b0, wu_d[63:40]}),
		.num_lo({wu_d[39:0], 24'b0}), .den(g_d), .quot(r_q)
	);

	ptw_divider #(.DW(64), .QW(GQW)) u_div_t2 (
		.clk(clk), .en(en), .num_hi({47'b0, num_s4[80:64]}),
		.num_lo(num_s4[63:0]), .den(g_d), .quot(t2_q)
	);

	ptw_divider #(.DW(64), .QW(GQW)) u_div_t3 (
		.clk(clk), .en(en), .num_hi(64'd0),
		.num_lo({9'b0, hmag_s4, 23'b0}), .den(g_d), .quot(t3_q)
	);

	logic        esg_d, hsg_d;
	logic [31:0] emag_d;

	ptw_delay #(.W(34), .DEPTH(K_DQ - K_S3)) u_dly_e (
		.clk(clk), .arst_n(arst_n), .en(en),
		.d({esg_s3, hsg_s3, emag_s3}), .q({esg_d, hsg_d, emag_d})
	);

	// t1 = |e| * r, capped; then the signed sum and the wqf product
	logic [63:0]        plo_s5, phi_s5, t2_s5, t3_s5, t2_s6, t3_s6, t2_s7, t3_s7;
	logic [1:0]         sg_s5, sg_s6, sg_s7;
	logic [95:0]        p_s6;
	logic [71:0]        t1_full;
	logic [63:0]        t1_s7;
	logic signed [63:0] s_s8;
	logic [63:0]        smag_s9;
	logic               sneg_s9, sneg_s10, sneg_s11;
	logic [47:0]        vlo_s10, vhi_s10;
	logic [79:0]        vp_s11;

	assign t1_full = p_s6[95:24];

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s5 <= emag_d * r_q[31:0];
			phi_s5 <= emag_d * r_q[63:32];
			t2_s5 <= t2_q;
			t3_s5 <= t3_q;
			sg_s5 <= {esg_d, hsg_d};
			p_s6 <= 96'(plo_s5) + {phi_s5, 32'b0};
			t2_s6 <= t2_s5;
			t3_s6 <= t3_s5;
			sg_s6 <= sg_s5;
			t1_s7 <= (t1_full > (72'd1 << 62)) ? (64'd1 << 62) : t1_full[63:0];
			t2_s7 <= t2_s6;
			t3_s7 <= t3_s6;
			sg_s7 <= sg_s6;
			s_s8 <= $signed(sg_s7[1] ? -t1_s7 : t1_s7) + $signed(t2_s7)
				+ $signed(sg_s7[0] ? -t3_s7 : t3_s7);
			sneg_s9 <= s_s8[63];
			smag_s9 <= s_s8[63] ? 64'(-s_s8) : 64'(s_s8);
			vlo_s10 <= smag_s9[31:0] * query_term_freq_q;
			vhi_s10 <= smag_s9[63:32] * query_term_freq_q;
			sneg_s10 <= sneg_s9;
			vp_s11 <= 80'(vlo_s10) + {vhi_s10, 32'b0};
			sneg_s11 <= sneg_s10;
		end
	end

	// rescale, saturate, apply short-cut cases
	logic [79:0]        v_sh;
	logic signed [31:0] wt;
	logic               inv_v;

	assign v_sh = vp_s11 >> SH;

	always_comb begin
		if (sneg_s11) begin
			wt = (v_sh > 80'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - v_sh[31:0]);
		end else begin
			wt = (v_sh > 80'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(v_sh[31:0]);
		end
		inv_v = 1'b0;
		if (flg_end.zero) begin
			wt = '0;
			inv_v = flg_end.inv;
		end
	end

	// valid travels alongside the words
	logic vld_d;

	ptw_delay #(.W(1), .DEPTH(K_OUT - 1)) u_dly_vld (
		.clk(clk), .arst_n(arst_n), .en(en), .d(item_valid), .q(vld_d)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			weight <= wt;
			invalid <= inv_v;
		end
	end

`ifndef NO_ASSERTIONS
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && invalid |-> weight == 32'sd0)
		else $error("invalid result with nonzero weight");

	a_vld_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_d |=> result_valid)
		else $error("word lost at output register");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_d && flg_end.zero |=> weight == 32'sd0 && invalid == $past(flg_end.inv))
		else $error("short-cut case not applied");
`endif

endmodule
`default_nettype wire
